// File: hdl/hufenc_pkg.sv
// ----------------------------------------------------------------------------
// hufenc_pkg
// Shared types and constants for the table-driven Huffman encoder and packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hufenc_pkg;

    // Operation carried by an input transaction; code 3 is unused.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_opcode;

    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;

endpackage : hufenc_pkg

`default_nettype wire

// File: hdl/huffman_table_encoder_packer.sv
// ----------------------------------------------------------------------------
// huffman_table_encoder_packer
// Huffman encoder with a loadable code table and a byte-wide bit packer.
//
// Input channel (i_in_valid / o_in_stall) carries load, encode and flush
// transactions. A load writes the symbol's length and code into the table
// on the cycle it is accepted and gives no output. An encode reads the
// table into the lookup stage on acceptance, then the packer appends the code to
// the pending bits and sends every full byte on the output channel
// (o_out_valid / i_out_stall), one byte per cycle while the receiver does not stall, earliest bit in bit 7.
// A flush sends the partial byte, zero padded, if bits are pending.
// A symbol without a code gives one flagged zero byte.
// From an idle block, a flush or missing-code byte passes through the lookup stage, then the output register;
// an encode passes through the lookup stage, the pending bits and then the output register. An encode's bytes
// leave one at a time through the single byte lane of the output register; the next item's table read overlaps
// that work, and a next encode with a code loads its bits in the same cycle as the last byte.
// Reset clears the table valid bits (every symbol has no code), the
// pending bits and all handshake state.
// While the receiver stalls, the output byte holds and the input stalls
// once the lookup stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_encoder_packer #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_symbol,
    input  wire logic [5:0]  i_code_length,
    input  wire logic [31:0] i_code_bits,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_symbol_missing
);

    localparam int WORK_W = MAX_CODE_LEN + hufenc_pkg::PEND_W;
    localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CNT_W  = $clog2(WORK_W + 1);
    localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENT_W  = LEN_W + CODE_W;

    // ------------------------------------------------------------------
    // Input side and table
    // ------------------------------------------------------------------
    hufenc_pkg::t_opcode in_op;
    logic                in_acc;
    logic                in_range;
    logic [IDX_W-1:0]    in_idx;
    logic [LEN_W-1:0]    wr_len;
    logic [CODE_W-1:0]   wr_code;

    logic [ENT_W-1:0]        r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_ent_vld;

    logic                r_s1_valid;
    hufenc_pkg::t_opcode r_s1_op;
    logic                r_s1_inr;
    logic                r_s1_vld;
    logic [ENT_W-1:0]    r_s1_ent;
    logic                s1_take;

    assign in_op    = hufenc_pkg::t_opcode'(i_opcode);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_range = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
    assign in_idx   = i_symbol[IDX_W-1:0];
    assign o_in_stall = r_s1_valid && !s1_take;

    always_comb begin
        if (i_code_length > 6'(MAX_CODE_LEN)) begin
            wr_len = LEN_W'(MAX_CODE_LEN);
        end else begin
            wr_len = LEN_W'(i_code_length);
        end
        // drop code bits above the length
        for (int i = 0; i < CODE_W; i++) begin
            wr_code[i] = i_code_bits[i] && (i < int'(wr_len));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (in_op == hufenc_pkg::OP_LOAD && in_range) begin
                r_mem[in_idx] <= {wr_len, wr_code};
            end
            r_s1_ent <= r_mem[in_idx];
            r_s1_vld <= r_ent_vld[in_idx];
            r_s1_inr <= in_range;
            r_s1_op  <= in_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc && in_op == hufenc_pkg::OP_LOAD && in_range) begin
                r_ent_vld[in_idx] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_valid <= (in_op == hufenc_pkg::OP_ENCODE) ||
                              (in_op == hufenc_pkg::OP_FLUSH);
            end else if (s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Packer: r_work holds unsent bits right-aligned, r_cnt their number
    // ------------------------------------------------------------------
    logic [WORK_W-1:0] r_work;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORK_W-1:0] n_work;
    logic [CNT_W-1:0]  n_cnt;

    logic [LEN_W-1:0]          s1_len;
    logic [CODE_W-1:0]         s1_code;
    logic                      s1_hit;
    logic [2:0]                left_cnt;
    logic [hufenc_pkg::PEND_W-1:0] left_bits;
    logic [WORK_W-1:0]         load_work;
    logic [CNT_W-1:0]          load_cnt;
    logic [WORK_W-1:0]         emit_shift;
    logic [hufenc_pkg::BYTE_W-1:0] flush_byte;
    logic                      out_free;
    logic                      emit;
    logic [hufenc_pkg::BYTE_W-1:0] emit_byte;
    logic                      emit_last;
    logic                      emit_miss;

    logic                          r_out_valid;
    logic [hufenc_pkg::BYTE_W-1:0] r_out_byte;
    logic                          r_out_last;
    logic                          r_out_miss;

    assign s1_len   = r_s1_ent[ENT_W-1 -: LEN_W];
    assign s1_code  = r_s1_ent[CODE_W-1:0];
    assign s1_hit   = r_s1_inr && r_s1_vld && (s1_len != '0);
    assign left_cnt = r_cnt[2:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int i = 0; i < hufenc_pkg::PEND_W; i++) begin
            left_bits[i] = r_work[i] && (i < int'(left_cnt));
        end
        load_work  = (WORK_W'(left_bits) << s1_len) | WORK_W'(s1_code);
        load_cnt   = CNT_W'(left_cnt) + CNT_W'(s1_len);
        emit_shift = r_work >> (r_cnt - CNT_W'(hufenc_pkg::BYTE_W));
        flush_byte = {left_bits, 1'b0} << (3'd7 - left_cnt);
    end

    always_comb begin
        n_work    = r_work;
        n_cnt     = r_cnt;
        s1_take   = 1'b0;
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        emit_miss = 1'b0;
        if (r_cnt >= CNT_W'(hufenc_pkg::BYTE_W)) begin
            if (out_free) begin
                emit      = 1'b1;
                emit_byte = emit_shift[hufenc_pkg::BYTE_W-1:0];
                emit_last = (r_cnt < CNT_W'(2 * hufenc_pkg::BYTE_W));
                n_cnt     = r_cnt - CNT_W'(hufenc_pkg::BYTE_W);
                // load the next code together with the final byte
                if (emit_last && r_s1_valid && r_s1_op == hufenc_pkg::OP_ENCODE &&
                    s1_hit) begin
                    n_work  = load_work;
                    n_cnt   = load_cnt;
                    s1_take = 1'b1;
                end
            end
        end else if (r_s1_valid) begin
            unique case (r_s1_op)
                hufenc_pkg::OP_ENCODE: begin
                    if (s1_hit) begin
                        n_work  = load_work;
                        n_cnt   = load_cnt;
                        s1_take = 1'b1;
                    end else if (out_free) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_miss = 1'b1;
                        s1_take   = 1'b1;
                    end
                end
                hufenc_pkg::OP_FLUSH: begin
                    if (left_cnt == 3'd0) begin
                        s1_take = 1'b1;
                    end else if (out_free) begin
                        emit      = 1'b1;
                        emit_byte = flush_byte;
                        emit_last = 1'b1;
                        n_cnt     = '0;
                        s1_take   = 1'b1;
                    end
                end
                default: begin
                    s1_take = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_work <= n_work;
            r_cnt  <= n_cnt;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
            r_out_miss <= emit_miss;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_run    = r_out_last;
    assign o_symbol_missing = r_out_miss;

endmodule : huffman_table_encoder_packer

`default_nettype wire
